/* rtl/crke_pkg.sv */
// Shared constants, types and helpers for the Catmull-Rom keyframe evaluator.
// No dependencies.
package crke_pkg;
  localparam int MaxKeys  = 16;
  localparam int FracBits = 16;
  localparam int IdxW     = $clog2(MaxKeys);
  localparam int CntW     = $clog2(MaxKeys + 1);
  localparam int NumCh    = 8;  // time, pos xyz, target xyz, fov
  localparam int ChW      = $clog2(NumCh);

  localparam logic [ChW-1:0] ChTime = 3'd0;
  localparam logic [ChW-1:0] ChFov  = 3'd7;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqEval = 1'b1;

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [NumCh*32-1:0] wdata;
  } key_wr_t;

  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) sat32 = 32'h7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) sat32 = 32'h8000_0000;
    else sat32 = v[31:0];
  endfunction
endpackage

/* rtl/crke_key_ram.sv */
// Keyframe table: one synchronous memory, one write and one read port.
// Depends on crke_pkg.
module crke_key_ram import crke_pkg::*; (
  input  logic                 clk,
  input  key_wr_t              wr,
  input  logic [IdxW-1:0]      raddr,
  output logic [NumCh*32-1:0]  rdata
);
  logic [NumCh*32-1:0] mem [MaxKeys];

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.waddr] <= wr.wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/crke_divider.sv */
// Restoring divider for the segment parameter: q = (num << FracBits) / den.
// Depends on crke_pkg.
module crke_divider import crke_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [FracBits:0] quo
);
  localparam int Steps = 32 + FracBits;
  logic [Steps-1:0] dvd_r;
  logic [32:0]      rem_r;
  logic [31:0]      den_r;
  logic [$clog2(Steps+1)-1:0] cnt_r;
  logic             busy_r;
  logic [32:0]      trial;

  assign trial = {rem_r[31:0], dvd_r[Steps-1]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= !start && busy_r && (cnt_r == ($clog2(Steps+1))'(Steps - 1));
      if (start) begin
        busy_r <= 1'b1;
        dvd_r  <= {num, {FracBits{1'b0}}};
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (!trial[32]) begin
          rem_r <= trial;
          dvd_r <= {dvd_r[Steps-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[31:0], dvd_r[Steps-1]};
          dvd_r <= {dvd_r[Steps-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(Steps+1))'(Steps - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
  // quotient bits shift into the dividend register
  assign quo = dvd_r[FracBits:0];
endmodule

/* rtl/catmull_rom_keyframe_evaluator.sv */
// Catmull-Rom keyframe evaluator top level.
// Depends on crke_pkg, crke_key_ram and crke_divider.
//
// Holds up to 16 keyframes in one synchronous table. A load request (tuser 0)
// writes one entry. An evaluate request (tuser 1) scans the table entry by
// entry for the first segment containing the query time, reads the segment's
// end times, runs a 48-step bit-serial divider for the segment parameter,
// reads the four control points, then evaluates the cubic for six coordinates
// and the field-of-view blend on one shared 48x18 multiplier, three products
// per coordinate and one for the blend. With two or more keys the time to the
// result is set by the scan, the divider and the shared multiplier. One request
// is in flight at a time; the result register holds until taken and the input
// stays closed until then. With key_count zero an evaluate gives no result;
// with one key entry 0 is returned as stored. key_count above 16 acts as 16.
module catmull_rom_keyframe_evaluator import crke_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // key_index[3:0], key_time, pos_x, pos_y, pos_z, target_x, target_y,
  // target_z, fov, eval_time (low to high), zero pad to 296 bits
  input  logic [295:0] in_tdata,
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, target_x, target_y, target_z, fov (low to high)
  output logic [223:0] out_tdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCANW, S_T0, S_T1, S_DIV, S_DIVW,
    S_RD, S_RDW, S_MUL, S_OUT
  } state_t;

  state_t state_r;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] n;
  logic [31:0] t_r, t0_r, t1_r, prev_t_r;
  logic [IdxW-1:0] seg_r, raddr;
  logic [CntW-1:0] scan_r;
  logic        found_r;
  logic [FracBits:0] s_r;
  logic [NumCh*32-1:0] rdata;
  logic [31:0] pts_r [NumCh][4];
  logic [1:0]  rd_r;
  logic [ChW-1:0] ch_r;
  logic [1:0]  ph_r;
  logic signed [47:0] h_r;
  logic [223:0] res_r;
  logic        out_v_r;
  key_wr_t     wr;
  logic        div_start, div_done;
  logic [FracBits:0] quo;

  assign n = (count_r > CntW'(MaxKeys)) ? CntW'(MaxKeys) : count_r;
  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata = res_r;

  // load path writes straight into the table
  assign wr.we    = in_tvalid && in_tready && (in_tuser == ReqLoad);
  assign wr.waddr = in_tdata[IdxW-1:0];
  assign wr.wdata = in_tdata[4 +: NumCh*32];

  // indices of the four control points
  logic [IdxW-1:0] idx [4];
  always_comb begin
    idx[0] = (seg_r == '0) ? seg_r : seg_r - 1'b1;
    idx[1] = seg_r;
    idx[2] = seg_r + 1'b1;
    idx[3] = ({1'b0, seg_r} + (IdxW+1)'(2) < (IdxW+1)'(n)) ? seg_r + IdxW'(2)
             : IdxW'(n - 1'b1);
  end

  always_comb begin
    case (state_r)
      S_SCAN:  raddr = scan_r[IdxW-1:0];
      S_T0:    raddr = seg_r;
      S_T1:    raddr = seg_r + 1'b1;
      S_RD:    raddr = idx[rd_r];
      default: raddr = '0;
    endcase
  end

  crke_key_ram u_ram (.clk(clk), .wr(wr), .raddr(raddr), .rdata(rdata));

  // start in S_DIV, where the end time of the segment is still on the read data
  assign div_start = (state_r == S_DIV);
  crke_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
    .num(t_r - t0_r), .den(rdata[31:0] - t0_r), .done(div_done), .quo(quo));

  // Shared multiplier: Horner step h*s >> F, or fov delta*s >> F.
  logic signed [47:0] p0, p1, p2, p3, cc, dd, bb, mop, acc;
  logic signed [82:0] prod;
  logic signed [47:0] shr;
  always_comb begin
    p0 = 48'(signed'(pts_r[ch_r][0]));
    p1 = 48'(signed'(pts_r[ch_r][1]));
    p2 = 48'(signed'(pts_r[ch_r][2]));
    p3 = 48'(signed'(pts_r[ch_r][3]));
    bb = p2 - p0;
    cc = (p0 <<< 1) - 5 * p1 + (p2 <<< 2) - p3;
    dd = -p0 + 3 * p1 - 3 * p2 + p3;
    if (ch_r == ChFov)
      mop = $signed({16'd0, pts_r[ChFov][2]}) - $signed({16'd0, pts_r[ChFov][1]});
    else
      mop = (ph_r == 2'd0) ? dd : h_r;
    prod = mop * $signed({1'b0, s_r});
    shr  = prod[FracBits +: 48];
    case (ph_r)
      2'd0:    acc = shr + cc;
      2'd1:    acc = shr + bb;
      default: acc = shr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) count_r <= cfg_wdata;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready && in_tuser == ReqEval && n != '0) begin
            t_r     <= in_tdata[260 +: 32];
            scan_r  <= '0;
            found_r <= 1'b0;
            if (n == CntW'(1)) begin
              seg_r <= '0;
              state_r <= S_T0;
            end else begin
              seg_r   <= IdxW'(n - 2'd2);
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: state_r <= S_SCANW;
        S_SCANW: begin
          // compare previous entry and this one as a segment
          if (scan_r != '0 && !found_r && t_r >= prev_t_r
              && t_r <= rdata[31:0]) begin
            found_r <= 1'b1;
            seg_r   <= IdxW'(scan_r - 1'b1);
          end
          prev_t_r <= rdata[31:0];
          if (scan_r == n - 1'b1) state_r <= S_T0;
          else begin
            scan_r  <= scan_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_T0: state_r <= S_T1;
        S_T1: begin
          t0_r <= rdata[31:0];
          state_r <= S_DIV;
        end
        S_DIV: begin
          t1_r <= rdata[31:0];
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (n == CntW'(1)) begin
            s_r <= '0;
            rd_r <= '0;
            state_r <= S_RD;
          end else if (div_done) begin
            if (t1_r <= t0_r || t_r <= t0_r) s_r <= '0;
            else if (t_r >= t1_r) s_r <= (FracBits+1)'(1) << FracBits;
            else s_r <= quo;
            rd_r <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          for (int c = 0; c < NumCh; c++) pts_r[c][rd_r] <= rdata[c*32 +: 32];
          if (rd_r == 2'd3) begin
            ch_r <= 3'd1;
            ph_r <= '0;
            state_r <= (n == CntW'(1)) ? S_OUT : S_MUL;
          end else begin
            rd_r <= rd_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_MUL: begin
          if (ch_r == ChFov) begin
            // blend stays between the two end values, so 32 bits suffice
            res_r[192 +: 32] <= pts_r[ChFov][1] + shr[31:0];
            state_r <= S_OUT;
          end else if (ph_r == 2'd2) begin
            res_r[(ch_r-1)*32 +: 32] <=
              sat32(((48'(signed'(pts_r[ch_r][1])) <<< 1) + acc) >>> 1);
            ph_r <= '0;
            ch_r <= ch_r + 1'b1;
          end else begin
            h_r  <= acc;
            ph_r <= ph_r + 1'b1;
          end
        end
        S_OUT: begin
          if (n == CntW'(1))
            for (int c = 1; c < NumCh; c++) res_r[(c-1)*32 +: 32] <= pts_r[c][1];
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
